[src/u2bd_pkg.sv]
// Shared types, constants and helper functions for the base-N digit converter.
package u2bd_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int STORE_DEPTH = VALUE_BITS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;
  localparam int IN_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((CHAR_W + 7) / 8) * 8;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] DEC_LIMIT  = BASE_W'(10);
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_HIGH = CHAR_W'(55);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WR,
    ST_RD,
    ST_EMIT
  } u2bd_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd_issue;
    logic rd_next;
  } u2bd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic quo_zero;
    logic store_full;
    logic rd_zero;
  } u2bd_sts_t;

  function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < DEC_LIMIT) r = {1'b0, d} + ASCII_ZERO;
    else r = {1'b0, d} + ASCII_HIGH;
    return r;
  endfunction

endpackage

[src/u2bd_ctrl.sv]
// Controller state machine: sequences division, digit store and digit emission.
module u2bd_ctrl
  import u2bd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  u2bd_sts_t sts,
  output u2bd_cmd_t cmd
);

  u2bd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_WR;
      end
      ST_WR: begin
        if (sts.quo_zero || sts.store_full) state_nxt = ST_RD;
        else state_nxt = ST_DIV;
      end
      ST_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready) begin
          if (sts.rd_zero) state_nxt = ST_IDLE;
          else state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_WR: begin
        cmd.store = 1'b1;
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
      end
      ST_EMIT: begin
        out_tvalid  = 1'b1;
        cmd.rd_next = out_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[src/u2bd_dp.sv]
// Datapath: radix register, bit-serial divider, remainder store and digit read-out.
module u2bd_dp
  import u2bd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr,
  input  logic [BASE_W-1:0]     cfg_base,
  input  logic [VALUE_BITS-1:0] in_value,
  input  u2bd_cmd_t             cmd,
  output u2bd_sts_t             sts,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last_digit
);

  logic [BASE_W-1:0]     digit_base_r;
  logic [BASE_W-1:0]     base_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [BASE_W-1:0]     rem_r;
  logic [BIT_CNT_W-1:0]  bit_cnt_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [ADDR_W-1:0]     rd_idx_r;
  logic [BASE_W-1:0]     rdata_r;
  logic [BASE_W-1:0]     mem [STORE_DEPTH];

  logic [BASE_W:0]       trial;
  logic [BASE_W:0]       diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, base_r};
  assign diff  = trial - {1'b0, base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_base_r <= BASE_RESET;
    end else if (cfg_wr) begin
      digit_base_r <= cfg_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r     <= '0;
      cnt_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.load) begin
      quo_r     <= in_value;
      cnt_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[VALUE_BITS-2:0], ge};
      bit_cnt_r <= bit_cnt_r + BIT_CNT_W'(1);
    end else if (cmd.store) begin
      cnt_r     <= cnt_r + CNT_W'(1);
      bit_cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= sat_base(digit_base_r);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
    end else if (cmd.store) begin
      rem_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r[ADDR_W-1:0]] <= rem_r;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rd_idx_r <= cnt_r[ADDR_W-1:0];
    end else if (cmd.rd_next) begin
      rd_idx_r <= rd_idx_r - ADDR_W'(1);
    end
  end

  assign sts.div_done   = bit_cnt_r == BIT_CNT_W'(VALUE_BITS - 1);
  assign sts.quo_zero   = quo_r == '0;
  assign sts.store_full = cnt_r == CNT_W'(STORE_DEPTH - 1);
  assign sts.rd_zero    = rd_idx_r == '0;

  assign digit_char = digit_ascii(rdata_r);
  assign last_digit = sts.rd_zero;

endmodule

[src/unsigned_to_base_digits.sv]
// Converts an unsigned value to ASCII digits in a configurable radix,
// most significant digit first.
//
// Input stream in_*: one transfer carries the value to convert in in_tdata.
// Output stream out_*: one transfer per digit, ASCII code in out_tdata[6:0],
// out_tlast set on the final (least significant) digit.
// Config port cfg_*: cfg_data[5:0] is the radix; 0/1 act as 2, above 36 as 36.
// Write it only while the block is idle; cfg_ready is always high.
//
// One value is converted at a time. Each digit is found by shifting the current
// quotient through the one-bit-per-cycle restoring divider and then writing
// the remainder to the digit store. Once the quotient is zero (or the store is
// full), each digit is read from the store and then output. A new value is
// taken only after the last digit's transfer.
// A stalled receiver holds the current digit; nothing else advances.
// Reset returns to idle with the radix at 16.
module unsigned_to_base_digits
  import u2bd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [63:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [6:0] digit_char, [7] zero
  output logic                  out_tlast,  // last_digit
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BASE_W-1:0]     cfg_data    // [5:0] digit_base
);

  u2bd_cmd_t         cmd;
  u2bd_sts_t         sts;
  logic [CHAR_W-1:0] digit_char;

  assign cfg_ready = 1'b1;

  u2bd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  u2bd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_base   (cfg_data),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .digit_char (digit_char),
    .last_digit (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - CHAR_W){1'b0}}, digit_char};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !out_tvalid)
    else $error("input transfer while a digit is pending");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after a transfer");

  a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
                    (digit_char >= 7'd65 && digit_char <= 7'd90)))
    else $error("digit outside ASCII digit range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("block not idle after last digit");

endmodule
